// ----- hdl/marker_field_extractor_top_assert.svh -----
// assertion macros shared by the marker field extractor modules
`ifndef MARKER_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define MARKER_FIELD_EXTRACTOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MFE_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MFE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MFE_ASSERT_IMPLY(label, ck, rn, ante, cons)
`define MFE_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

// ----- hdl/mfe_pkg.sv -----
// shared types and constants of the marker field extractor
`default_nettype none

package mfe_pkg;

    localparam int BYTE_W      = 8;
    localparam int MARKER_W    = 64;
    localparam int MLEN_W      = 4;
    localparam int FIELD_LEN_W = 16;
    localparam int CFG_IDX_W   = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_MARKER_BYTES  = 2'd0;
    localparam cfg_index_t CFG_MARKER_LENGTH = 2'd1;
    localparam cfg_index_t CFG_FIELD_LENGTH  = 2'd2;

    typedef enum logic [1:0] {
        ST_FIELD     = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_TRUNC     = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        status_t           status;
        logic              last_result;
    } mfe_result_t;

endpackage

`default_nettype wire

// ----- hdl/mfe_cell.sv -----
// one byte cell of the marker compare chain
`default_nettype none

module mfe_cell
    import mfe_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic                clk,
    input  wire logic                shift_en,
    input  wire logic [MARKER_W-1:0] marker_bytes,
    input  wire logic [MLEN_W-1:0]   marker_length,
    input  wire logic [BYTE_W-1:0]   in_byte,
    input  wire logic                match_in,
    output logic      [BYTE_W-1:0]   out_byte,
    output logic                     match_out
);

    localparam int SEL_W = $clog2(MARKER_W / BYTE_W);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic [SEL_W-1:0]  sel;
    logic [BYTE_W-1:0] want;
    logic              active;
    logic              eq;

    // cell IDX sees the byte of age IDX and checks marker byte length-1-IDX
    always_comb
    begin
        active    = marker_length > MLEN_W'(IDX);
        sel       = SEL_W'(marker_length - MLEN_W'(IDX) - MLEN_W'(1));
        want      = marker_bytes[{sel, 3'b000} +: BYTE_W];
        eq        = !active || (in_byte == want);
        match_out = match_in && eq;
        byte_next = shift_en ? in_byte : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign out_byte = byte_reg;

endmodule

`default_nettype wire

// ----- hdl/mfe_ctrl.sv -----
// search and extraction control with block position and field countdown
`default_nettype none
`include "marker_field_extractor_top_assert.svh"

module mfe_ctrl
    import mfe_pkg::*;
#(
    parameter int SEARCH_WINDOW = 512,
    parameter int MARKER_MAX    = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [BYTE_W-1:0]      data_byte,
    input  wire logic                   block_end,
    input  wire logic                   chain_match,
    input  wire logic [MLEN_W-1:0]      marker_length,
    input  wire logic [FIELD_LEN_W-1:0] field_length,
    output logic                        push,
    output mfe_result_t                 res
);

    localparam int CW = $clog2(SEARCH_WINDOW + 1);

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_EXTRACT = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [CW-1:0]          seen_reg;
    logic [CW-1:0]          seen_next;
    logic [FIELD_LEN_W-1:0] left_reg;
    logic [FIELD_LEN_W-1:0] left_next;
    logic [FIELD_LEN_W-1:0] left_dec;
    logic                   len_ok;
    logic                   pos_ok;
    logic                   window_ok;
    logic                   hit;
    logic                   res_valid;

    always_comb
    begin
        len_ok    = (marker_length != '0) && (marker_length <= MLEN_W'(MARKER_MAX));
        pos_ok    = ((CW+1)'(seen_reg) + (CW+1)'(1)) >= (CW+1)'(marker_length);
        window_ok = seen_reg < CW'(SEARCH_WINDOW);
        hit       = chain_match && len_ok && pos_ok && window_ok;
        left_dec  = left_reg - FIELD_LEN_W'(1);

        phase_next      = phase_reg;
        seen_next       = seen_reg;
        left_next       = left_reg;
        res_valid       = 1'b0;
        res.out_byte    = '0;
        res.status      = ST_FIELD;
        res.last_result = 1'b0;

        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (hit)
                begin
                    if (field_length == '0)
                    begin
                        res_valid       = 1'b1;
                        res.status      = ST_EMPTY;
                        res.last_result = 1'b1;
                        phase_next      = PH_DONE;
                    end
                    else if (block_end)
                    begin
                        res_valid       = 1'b1;
                        res.out_byte    = data_byte;
                        res.status      = ST_TRUNC;
                        res.last_result = 1'b1;
                    end
                    else
                    begin
                        left_next  = field_length;
                        phase_next = PH_EXTRACT;
                    end
                end
                else if (block_end)
                begin
                    res_valid       = 1'b1;
                    res.status      = ST_NOT_FOUND;
                    res.last_result = 1'b1;
                end
            end
            PH_EXTRACT:
            begin
                left_next    = left_dec;
                res_valid    = 1'b1;
                res.out_byte = data_byte;
                if (left_dec == '0)
                begin
                    res.last_result = 1'b1;
                    phase_next      = PH_DONE;
                end
                else if (block_end)
                begin
                    res.status      = ST_TRUNC;
                    res.last_result = 1'b1;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase

        if (seen_reg < CW'(SEARCH_WINDOW))
        begin
            seen_next = seen_reg + CW'(1);
        end

        // block end returns to searching
        if (block_end)
        begin
            phase_next = PH_SEARCH;
            seen_next  = '0;
            left_next  = '0;
        end

        push = accept && res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            seen_reg  <= '0;
            left_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            left_reg  <= left_next;
        end
    end

    `MFE_ASSERT_IMPLY(a_extract_owes, clk, rst_n, phase_reg == PH_EXTRACT, left_reg != '0)
    `MFE_ASSERT_NEXT(a_end_clears, clk, rst_n, accept && block_end, phase_reg == PH_SEARCH && seen_reg == '0 && left_reg == '0)
    `MFE_ASSERT_IMPLY(a_mid_field, clk, rst_n, push && !res.last_result, phase_reg == PH_EXTRACT && res.status == ST_FIELD)

endmodule

`default_nettype wire

// ----- hdl/mfe_out_buf.sv -----
// output register with skid entry for the result channel
`default_nettype none
`include "marker_field_extractor_top_assert.svh"

module mfe_out_buf
    import mfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire mfe_result_t res,
    input  wire logic        out_stall,
    output logic             out_valid,
    output mfe_result_t      out_res,
    output logic             full
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    mfe_result_t out_reg;
    mfe_result_t out_next;
    mfe_result_t skid_reg;
    mfe_result_t skid_next;
    logic        out_take;

    always_comb
    begin
        out_take        = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign full      = skid_valid_reg;

    `MFE_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `MFE_ASSERT_NEXT(a_no_drop, clk, rst_n, push && out_valid_reg && out_stall, skid_valid_reg)

endmodule

`default_nettype wire

// ----- hdl/marker_field_extractor_top.sv -----
// top level of the marker field extractor
`default_nettype none

// Takes one byte per cycle while in_stall is low and gives at most one result per byte, which
// is registered in the output register or the skid entry. A row of MARKER_MAX compare cells
// holds the latest bytes and checks them against the marker in parallel, so the byte rate is
// one per cycle with no gaps; in_stall rises only while a result waits in the skid entry
// behind a stalled output register. Configuration writes are always taken (cfg_ready is tied
// high) and apply from the next byte on; write them only while no block is in progress.
module marker_field_extractor_top
    import mfe_pkg::*;
#(
    parameter int SEARCH_WINDOW = 512,
    parameter int MARKER_MAX    = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                block_end,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [BYTE_W-1:0]   out_byte,
    output logic      [1:0]          status,
    output logic                     last_result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MARKER_W-1:0] cfg_data
);

    logic [MARKER_W-1:0]    marker_bytes_reg;
    logic [MLEN_W-1:0]      marker_length_reg;
    logic [FIELD_LEN_W-1:0] field_length_reg;
    logic                   accept;
    logic                   push;
    logic                   buf_full;
    mfe_result_t            res;
    mfe_result_t            out_res;

    logic [BYTE_W-1:0]      chain_byte [MARKER_MAX+1];
    logic                   chain_match [MARKER_MAX+1];

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_bytes_reg  <= '0;
            marker_length_reg <= '0;
            field_length_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MARKER_BYTES:  marker_bytes_reg  <= cfg_data;
                CFG_MARKER_LENGTH: marker_length_reg <= cfg_data[MLEN_W-1:0];
                CFG_FIELD_LENGTH:  field_length_reg  <= cfg_data[FIELD_LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign chain_byte[0]  = data_byte;
    assign chain_match[0] = 1'b1;

    for (genvar k = 0; k < MARKER_MAX; k++)
    begin : g_cell
        mfe_cell #(
            .IDX (k)
        ) u_cell (
            .clk           (clk),
            .shift_en      (accept),
            .marker_bytes  (marker_bytes_reg),
            .marker_length (marker_length_reg),
            .in_byte       (chain_byte[k]),
            .match_in      (chain_match[k]),
            .out_byte      (chain_byte[k+1]),
            .match_out     (chain_match[k+1])
        );
    end

    mfe_ctrl #(
        .SEARCH_WINDOW (SEARCH_WINDOW),
        .MARKER_MAX    (MARKER_MAX)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .block_end     (block_end),
        .chain_match   (chain_match[MARKER_MAX]),
        .marker_length (marker_length_reg),
        .field_length  (field_length_reg),
        .push          (push),
        .res           (res)
    );

    mfe_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .full      (buf_full)
    );

    assign out_byte    = out_res.out_byte;
    assign status      = out_res.status;
    assign last_result = out_res.last_result;

endmodule

`default_nettype wire
